FILE: hw/rtl/oal_pkg.sv
// Shared types and constants for the ordered array list.
package oal_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int MAX_OUT      = 64;

  localparam int KIND_W    = 2;
  localparam int POS_W     = 6;
  localparam int VAL_W     = 32;
  localparam int STATUS_W  = 2;
  localparam int INDEX_W   = 6;
  localparam int ENTRIES_W = 7;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_DUMP   = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_BADPOS = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_APPEND = 3'd1,
    CELL_INSERT = 3'd2,
    CELL_DELETE = 3'd3,
    CELL_ROTATE = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctl_t;

  typedef struct packed {
    status_t                status;
    logic [VAL_W-1:0]       data;
    logic [INDEX_W-1:0]     index;
    logic [ENTRIES_W-1:0]   entries;
    logic                   last;
  } result_t;

endpackage

FILE: hw/rtl/ordered_array_list_top.sv
// Ordered array list: a row of CAPACITY cells with append, insert, delete and dump.
// Append, insert and delete, and any rejected request, are handled when taken: every
// cell shifts or loads in the same edge and one result word is queued. A dump
// queues nothing in the cycle it is taken, then does one rotation of the cell row per
// cycle with the head cell read out, so the row is back in order at the end; a
// full output queue pauses the rotation. Results go out for the first 64
// entries only. Input is taken only when no dump is running and the two-word
// output queue has room, so a full queue holds the input side.
module ordered_array_list_top #(
  parameter int CAPACITY = oal_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [5:0] position, [37:6] value, [39:38] zero
  input  logic [oal_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [1:0] kind
  input  logic [oal_pkg::KIND_W-1:0]       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [31:0] data, [37:32] index, [44:38] entries, [47:45] zero
  output logic [oal_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [1:0] status
  output logic [oal_pkg::STATUS_W-1:0]     out_tuser,
  output logic                             out_tlast
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > oal_pkg::POS_W) ? CNT_W : oal_pkg::POS_W) + 1;
  localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);
  localparam logic [CMP_W-1:0] MAX_C = CMP_W'(oal_pkg::MAX_OUT);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   dptr_r, dptr_nxt;

  logic [oal_pkg::POS_W-1:0] in_pos;
  logic [oal_pkg::VAL_W-1:0] in_val;
  oal_pkg::kind_t            in_kind;
  logic                      in_fire;

  oal_pkg::cell_ctl_t        ctl;
  logic [IDX_W-1:0]          sel;
  logic [oal_pkg::VAL_W-1:0] cq [CAPACITY];
  logic [oal_pkg::VAL_W-1:0] crd [CAPACITY];
  logic [oal_pkg::VAL_W-1:0] del_val;

  logic              q_room, q_push;
  oal_pkg::result_t  q_word, res;
  logic [CMP_W-1:0]  cnt_w, pos_w, dptr_w;
  logic              full, empty, pos_bad, emit, step, dump_end;

  assign in_pos  = in_tdata[oal_pkg::POS_W-1:0];
  assign in_val  = in_tdata[oal_pkg::POS_W +: oal_pkg::VAL_W];
  assign in_kind = oal_pkg::kind_t'(in_tuser);

  assign in_tready = (state_r == ST_IDLE) && q_room;
  assign in_fire   = in_tvalid && in_tready;

  assign cnt_w   = CMP_W'(count_r);
  assign pos_w   = CMP_W'(in_pos);
  assign dptr_w  = CMP_W'(dptr_r);
  assign full    = (cnt_w >= CAP_C);
  assign empty   = (count_r == '0);
  assign pos_bad = (pos_w >= cnt_w);

  assign emit     = (dptr_w < MAX_C);
  assign step     = !emit || q_room;
  assign dump_end = (dptr_r == count_r - CNT_W'(1));

  // read-out of the slot being deleted
  always_comb begin
    del_val = '0;
    for (int i = 0; i < CAPACITY; i++) del_val = del_val | crd[i];
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    dptr_nxt   = dptr_r;
    ctl.op     = oal_pkg::CELL_HOLD;
    sel        = IDX_W'(in_pos);
    q_push     = 1'b0;
    res.status = oal_pkg::STAT_OK;
    res.data   = '0;
    res.index  = '0;
    res.entries = oal_pkg::ENTRIES_W'(count_r);
    res.last   = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          q_push = 1'b1;
          case (in_kind)
            oal_pkg::KIND_APPEND: begin
              sel = IDX_W'(count_r);
              if (full) begin
                res.status = oal_pkg::STAT_FULL;
              end else begin
                ctl.op      = oal_pkg::CELL_APPEND;
                count_nxt   = count_r + CNT_W'(1);
                res.index   = oal_pkg::INDEX_W'(count_r);
                res.entries = oal_pkg::ENTRIES_W'(count_nxt);
              end
            end
            oal_pkg::KIND_INSERT: begin
              if (full) begin
                res.status = oal_pkg::STAT_FULL;
              end else if (pos_bad) begin
                res.status = oal_pkg::STAT_BADPOS;
              end else begin
                ctl.op      = oal_pkg::CELL_INSERT;
                count_nxt   = count_r + CNT_W'(1);
                res.index   = in_pos;
                res.entries = oal_pkg::ENTRIES_W'(count_nxt);
              end
            end
            oal_pkg::KIND_DELETE: begin
              if (empty) begin
                res.status = oal_pkg::STAT_EMPTY;
              end else if (pos_bad) begin
                res.status = oal_pkg::STAT_BADPOS;
              end else begin
                ctl.op      = oal_pkg::CELL_DELETE;
                count_nxt   = count_r - CNT_W'(1);
                res.data    = del_val;
                res.index   = in_pos;
                res.entries = oal_pkg::ENTRIES_W'(count_nxt);
              end
            end
            oal_pkg::KIND_DUMP: begin
              if (empty) begin
                res.status = oal_pkg::STAT_EMPTY;
              end else begin
                q_push    = 1'b0;
                dptr_nxt  = '0;
                state_nxt = ST_DUMP;
              end
            end
            default: res.status = oal_pkg::STAT_OK;
          endcase
        end
      end
      ST_DUMP: begin
        sel = IDX_W'(count_r - CNT_W'(1));
        if (step) begin
          ctl.op    = oal_pkg::CELL_ROTATE;
          q_push    = emit;
          res.data  = cq[0];
          res.index = oal_pkg::INDEX_W'(dptr_r);
          res.last  = ((dptr_w + CMP_W'(1)) == cnt_w) || ((dptr_w + CMP_W'(1)) == MAX_C);
          dptr_nxt  = dptr_r + CNT_W'(1);
          if (dump_end) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    q_word = res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      dptr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      dptr_r  <= dptr_nxt;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [oal_pkg::VAL_W-1:0] lft, rgt;
    if (g == 0) begin : g_head
      assign lft = '0;
    end else begin : g_mid_l
      assign lft = cq[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign rgt = cq[g];
    end else begin : g_mid_r
      assign rgt = cq[g+1];
    end
    oal_cell #(
      .IDX_W (IDX_W),
      .IDX   (g)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .sel   (sel),
      .wval  (in_val),
      .left  (lft),
      .right (rgt),
      .first (cq[0]),
      .q     (cq[g]),
      .rd    (crd[g])
    );
  end

  oal_pkg::result_t out_word;

  oal_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (q_word),
    .room      (q_room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (out_word)
  );

  assign out_tdata = {3'b000, out_word.entries, out_word.index, out_word.data};
  assign out_tuser = out_word.status;
  assign out_tlast = out_word.last;

endmodule

FILE: hw/rtl/oal_cell.sv
// One list slot: holds an entry and trades it with its neighbors.
module oal_cell #(
  parameter int IDX_W = 6,
  parameter int IDX   = 0
) (
  input  logic                        clk,
  input  oal_pkg::cell_ctl_t          ctl,
  input  logic [IDX_W-1:0]            sel,
  input  logic [oal_pkg::VAL_W-1:0]   wval,
  input  logic [oal_pkg::VAL_W-1:0]   left,
  input  logic [oal_pkg::VAL_W-1:0]   right,
  input  logic [oal_pkg::VAL_W-1:0]   first,
  output logic [oal_pkg::VAL_W-1:0]   q,
  output logic [oal_pkg::VAL_W-1:0]   rd
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [oal_pkg::VAL_W-1:0] val_r, val_nxt;
  logic                      hit, above;

  assign hit   = (sel == MY_IDX);
  assign above = (MY_IDX > sel);

  always_comb begin
    val_nxt = val_r;
    case (ctl.op)
      oal_pkg::CELL_APPEND: begin
        if (hit) val_nxt = wval;
      end
      oal_pkg::CELL_INSERT: begin
        if (hit) val_nxt = wval;
        else if (above) val_nxt = left;
      end
      oal_pkg::CELL_DELETE: begin
        if (hit || above) val_nxt = right;
      end
      // head entry wraps around to the last live slot
      oal_pkg::CELL_ROTATE: begin
        val_nxt = hit ? first : right;
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign q  = val_r;
  assign rd = hit ? val_r : '0;

endmodule

FILE: hw/rtl/oal_outq.sv
// Two-word result queue between the list and the output stream.
module oal_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  oal_pkg::result_t  push_word,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output oal_pkg::result_t  out_word
);

  oal_pkg::result_t mem_r [2];
  logic             wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign room      = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_word  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_word;
  end

endmodule
